FILE: hdl/script_number_literal_matcher_core_macros.svh
// Assertion macros for the numeric literal matcher.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef SCRIPT_NUMBER_LITERAL_MATCHER_CORE_MACROS_SVH
`define SCRIPT_NUMBER_LITERAL_MATCHER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define SNLM_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SNLM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/snlm_pkg.sv
// Shared types, scan phase codes, register indexes, character constants and
// class helpers for the numeric literal matcher. No dependencies.
`default_nettype none

package snlm_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_char;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic       matched;
    logic [7:0] match_length;
  } out_t;

  typedef struct packed {
    logic allow_separators;
    logic allow_octal_prefix;
    logic allow_binary_prefix;
    logic allow_bigint_suffix;
  } cfg_t;

  // configuration register indexes (byte address 4*i)
  localparam logic [1:0] REG_SEPARATORS = 2'd0;
  localparam logic [1:0] REG_OCTAL      = 2'd1;
  localparam logic [1:0] REG_BINARY     = 2'd2;
  localparam logic [1:0] REG_BIGINT     = 2'd3;

  localparam int PH_W = 4;

  localparam logic [PH_W-1:0] PH_START   = 4'd0;
  localparam logic [PH_W-1:0] PH_SIGN    = 4'd1;
  localparam logic [PH_W-1:0] PH_ZERO    = 4'd2;
  localparam logic [PH_W-1:0] PH_INT     = 4'd3;
  localparam logic [PH_W-1:0] PH_FRAC    = 4'd4;
  localparam logic [PH_W-1:0] PH_LEADDOT = 4'd5;
  localparam logic [PH_W-1:0] PH_EXP     = 4'd6;
  localparam logic [PH_W-1:0] PH_EXPDIG  = 4'd7;
  localparam logic [PH_W-1:0] PH_HEX     = 4'd8;
  localparam logic [PH_W-1:0] PH_BIN     = 4'd9;
  localparam logic [PH_W-1:0] PH_OCT     = 4'd10;

  typedef struct packed {
    logic [PH_W-1:0] phase;
    logic            prev_was_digit;
    logic            digit_seen;
    logic            saw_point;
    logic            saw_exponent;
    logic            signed_start;
    logic            decided;
  } scan_t;

  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_ONE        = 8'h31;
  localparam logic [7:0] CH_SEVEN      = 8'h37;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_B    = 8'h42;
  localparam logic [7:0] CH_UPPER_E    = 8'h45;
  localparam logic [7:0] CH_UPPER_F    = 8'h46;
  localparam logic [7:0] CH_UPPER_O    = 8'h4F;
  localparam logic [7:0] CH_UPPER_X    = 8'h58;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_B    = 8'h62;
  localparam logic [7:0] CH_LOWER_E    = 8'h65;
  localparam logic [7:0] CH_LOWER_F    = 8'h66;
  localparam logic [7:0] CH_LOWER_N    = 8'h6E;
  localparam logic [7:0] CH_LOWER_O    = 8'h6F;
  localparam logic [7:0] CH_LOWER_X    = 8'h78;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // digit class of the current run
  function automatic logic digit_for(input logic [7:0] c, input logic [PH_W-1:0] ph);
    logic r;
    if (ph == PH_HEX) begin
      r = is_dec(c) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) ||
          ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
    end else if (ph == PH_BIN) begin
      r = (c == CH_ZERO) || (c == CH_ONE);
    end else if (ph == PH_OCT) begin
      r = (c >= CH_ZERO) && (c <= CH_SEVEN);
    end else begin
      r = is_dec(c);
    end
    return r;
  endfunction

  function automatic logic needs_digits(input logic [PH_W-1:0] ph);
    return (ph == PH_LEADDOT) || (ph == PH_EXP) || (ph == PH_EXPDIG) ||
           (ph == PH_HEX) || (ph == PH_BIN) || (ph == PH_OCT);
  endfunction

  // true when the literal may legally end in this state
  function automatic logic run_ok(input logic [PH_W-1:0] ph, input logic dig,
                                  input logic prev);
    logic r;
    r = 1'b1;
    if ((ph == PH_START) || (ph == PH_SIGN)) r = 1'b0;
    if (dig && !prev) r = 1'b0;
    if (needs_digits(ph) && !dig) r = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/snlm_step.sv
// Per-character transition of the numeric literal scanner: next scan state,
// next length, and the result word when the scan is decided. Uses snlm_pkg.
`default_nettype none

module snlm_step #(
  parameter int MAX_LEN = 255,
  parameter int LEN_W   = 8
) (
  input  snlm_pkg::in_t      in_item,
  input  snlm_pkg::cfg_t     cfg,
  input  snlm_pkg::scan_t    st_cur,
  input  logic [LEN_W-1:0]   len_cur,
  output snlm_pkg::scan_t    st_nxt,
  output logic [LEN_W-1:0]   len_nxt,
  output logic               emit,
  output snlm_pkg::out_t     res
);

  always_comb begin
    logic [7:0]                c;
    logic [snlm_pkg::PH_W-1:0] ph;
    logic [snlm_pkg::PH_W-1:0] nx;
    logic                      skip;
    logic                      fail;
    logic                      do_take;
    logic                      end_now;
    logic                      take_end;
    logic                      ok;

    st_nxt   = st_cur;
    len_nxt  = len_cur;
    emit     = 1'b0;
    res      = '0;
    c        = in_item.char_code;
    skip     = 1'b0;
    fail     = 1'b0;
    do_take  = 1'b0;
    end_now  = 1'b0;
    take_end = 1'b0;
    ok       = 1'b0;

    // restart on a first character, otherwise drop bytes once decided
    if (in_item.first_char) begin
      st_nxt.phase          = snlm_pkg::PH_START;
      st_nxt.prev_was_digit = 1'b0;
      st_nxt.digit_seen     = 1'b0;
      st_nxt.saw_point      = 1'b0;
      st_nxt.saw_exponent   = 1'b0;
      st_nxt.signed_start   = 1'b0;
      st_nxt.decided        = 1'b0;
      len_nxt               = '0;
    end else if (st_cur.decided) begin
      skip = 1'b1;
    end

    ph = st_nxt.phase;
    nx = ph;

    if (!skip) begin
      if ((ph == snlm_pkg::PH_START) || (ph == snlm_pkg::PH_SIGN)) begin
        if ((ph == snlm_pkg::PH_START) &&
            ((c == snlm_pkg::CH_PLUS) || (c == snlm_pkg::CH_MINUS))) begin
          st_nxt.signed_start = 1'b1;
          do_take = 1'b1;
          nx = snlm_pkg::PH_SIGN;
        end else if (c == snlm_pkg::CH_ZERO) begin
          st_nxt.prev_was_digit = 1'b0;
          st_nxt.digit_seen     = 1'b0;
          do_take = 1'b1;
          nx = snlm_pkg::PH_ZERO;
        end else if (snlm_pkg::is_dec(c)) begin
          st_nxt.prev_was_digit = 1'b1;
          st_nxt.digit_seen     = 1'b1;
          do_take = 1'b1;
          nx = snlm_pkg::PH_INT;
        end else if (c == snlm_pkg::CH_DOT) begin
          st_nxt.prev_was_digit = 1'b0;
          st_nxt.digit_seen     = 1'b0;
          st_nxt.saw_point      = 1'b1;
          do_take = 1'b1;
          nx = snlm_pkg::PH_LEADDOT;
        end else begin
          fail = 1'b1;
        end
      end else if ((ph == snlm_pkg::PH_ZERO) &&
                   ((c == snlm_pkg::CH_LOWER_X) || (c == snlm_pkg::CH_UPPER_X) ||
                    (c == snlm_pkg::CH_LOWER_B) || (c == snlm_pkg::CH_UPPER_B) ||
                    (c == snlm_pkg::CH_LOWER_O) || (c == snlm_pkg::CH_UPPER_O))) begin
        if ((c == snlm_pkg::CH_LOWER_X) || (c == snlm_pkg::CH_UPPER_X)) begin
          nx = snlm_pkg::PH_HEX;
        end else if ((c == snlm_pkg::CH_LOWER_B) || (c == snlm_pkg::CH_UPPER_B)) begin
          nx = snlm_pkg::PH_BIN;
        end else begin
          nx = snlm_pkg::PH_OCT;
        end
        if (st_nxt.signed_start) begin
          fail = 1'b1;
        end else if ((nx == snlm_pkg::PH_BIN) && !cfg.allow_binary_prefix) begin
          fail = 1'b1;
        end else if ((nx == snlm_pkg::PH_OCT) && !cfg.allow_octal_prefix) begin
          fail = 1'b1;
        end else begin
          st_nxt.prev_was_digit = 1'b0;
          st_nxt.digit_seen     = 1'b0;
          do_take = 1'b1;
        end
      end else if ((ph == snlm_pkg::PH_ZERO) && snlm_pkg::is_dec(c)) begin
        st_nxt.prev_was_digit = 1'b1;
        st_nxt.digit_seen     = 1'b1;
        do_take = 1'b1;
        nx = snlm_pkg::PH_INT;
      end else if ((ph == snlm_pkg::PH_EXP) &&
                   ((c == snlm_pkg::CH_PLUS) || (c == snlm_pkg::CH_MINUS))) begin
        do_take = 1'b1;
        nx = snlm_pkg::PH_EXPDIG;
      end else if ((ph != snlm_pkg::PH_ZERO) && snlm_pkg::digit_for(c, ph)) begin
        st_nxt.prev_was_digit = 1'b1;
        st_nxt.digit_seen     = 1'b1;
        do_take = 1'b1;
        nx = (ph == snlm_pkg::PH_EXP) ? snlm_pkg::PH_EXPDIG : ph;
      end else if (c == snlm_pkg::CH_UNDERSCORE) begin
        if (!cfg.allow_separators || !st_nxt.prev_was_digit) begin
          fail = 1'b1;
        end else begin
          st_nxt.prev_was_digit = 1'b0;
          do_take = 1'b1;
        end
      end else begin
        // byte does not continue the current digit run
        if (!snlm_pkg::run_ok(ph, st_nxt.digit_seen, st_nxt.prev_was_digit)) begin
          fail = 1'b1;
        end else if (c == snlm_pkg::CH_LOWER_N) begin
          if (st_nxt.saw_point || st_nxt.saw_exponent) begin
            fail = 1'b1;
          end else if (!cfg.allow_bigint_suffix) begin
            end_now = 1'b1;
          end else begin
            do_take  = 1'b1;
            take_end = 1'b1;
          end
        end else if (((ph == snlm_pkg::PH_ZERO) || (ph == snlm_pkg::PH_INT)) &&
                     (c == snlm_pkg::CH_DOT)) begin
          st_nxt.saw_point      = 1'b1;
          st_nxt.prev_was_digit = 1'b0;
          st_nxt.digit_seen     = 1'b0;
          do_take = 1'b1;
          nx = snlm_pkg::PH_FRAC;
        end else if (((ph == snlm_pkg::PH_ZERO) || (ph == snlm_pkg::PH_INT) ||
                      (ph == snlm_pkg::PH_FRAC) || (ph == snlm_pkg::PH_LEADDOT)) &&
                     ((c == snlm_pkg::CH_LOWER_E) || (c == snlm_pkg::CH_UPPER_E))) begin
          st_nxt.saw_exponent   = 1'b1;
          st_nxt.prev_was_digit = 1'b0;
          st_nxt.digit_seen     = 1'b0;
          do_take = 1'b1;
          nx = snlm_pkg::PH_EXP;
        end else begin
          end_now = 1'b1;
        end
      end

      // length limit check, then close the scan if the byte or the string ends it
      if (fail || (do_take && (len_nxt >= LEN_W'(MAX_LEN)))) begin
        emit = 1'b1;
      end else begin
        if (do_take) begin
          len_nxt      = len_nxt + LEN_W'(1);
          st_nxt.phase = nx;
        end
        if (end_now || take_end) begin
          emit             = 1'b1;
          res.matched      = 1'b1;
          res.match_length = 8'(len_nxt);
        end else if (in_item.last_char) begin
          emit             = 1'b1;
          ok               = snlm_pkg::run_ok(st_nxt.phase, st_nxt.digit_seen,
                                              st_nxt.prev_was_digit);
          res.matched      = ok;
          res.match_length = ok ? 8'(len_nxt) : 8'd0;
        end
      end

      if (emit) st_nxt.decided = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/script_number_literal_matcher_core.sv
// Top level of the numeric literal matcher: input word register, scan state,
// result register and APB register file. Uses snlm_pkg, snlm_step, macros header.
`default_nettype none
`include "script_number_literal_matcher_core_macros.svh"

// Scans one character per input word and reports one result word per scan:
// whether a numeric literal (optional sign, decimal with fraction and
// exponent, or 0x/0b/0o integer, optional BigInt n) starts at the word flagged
// first_char, and its length. The result is given on the word that ends the
// literal or on the last_char word; words after it are dropped until the next
// first_char. A new word is taken every cycle unless a pending result waits
// for out_ready. Each word is held in the input register, the combinational
// per-character state update reads it, and any result loads the result
// register once that register can take it; the state update sets that rate.
// Literals longer than MAX_LEN fail; match_length holds the low 8 bits.
// Configuration registers (byte address 4*i): allow_separators,
// allow_octal_prefix, allow_binary_prefix, allow_bigint_suffix; write them
// only while no scan word is in flight.
module script_number_literal_matcher_core #(
  parameter int MAX_LEN = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  snlm_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output snlm_pkg::out_t      out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  snlm_pkg::cfg_t   cfg_r;
  logic             in_valid_r;
  snlm_pkg::in_t    in_data_r;
  snlm_pkg::scan_t  st_r;
  snlm_pkg::scan_t  st_nxt;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic             out_valid_r;
  snlm_pkg::out_t   out_data_r;
  logic             step_emit;
  snlm_pkg::out_t   step_res;
  logic             s1_go;
  logic             cfg_wr;

  // advance the held word once the result register can take it
  assign s1_go    = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || s1_go;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  snlm_step #(
    .MAX_LEN (MAX_LEN),
    .LEN_W   (LEN_W)
  ) u_step (
    .in_item (in_data_r),
    .cfg     (cfg_r),
    .st_cur  (st_r),
    .len_cur (len_r),
    .st_nxt  (st_nxt),
    .len_nxt (len_nxt),
    .emit    (step_emit),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      st_r.phase          <= snlm_pkg::PH_START;
      st_r.prev_was_digit <= 1'b0;
      st_r.digit_seen     <= 1'b0;
      st_r.saw_point      <= 1'b0;
      st_r.saw_exponent   <= 1'b0;
      st_r.signed_start   <= 1'b0;
      st_r.decided        <= 1'b1;
      len_r               <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (s1_go) begin
        in_valid_r <= 1'b0;
      end
      if (s1_go) begin
        st_r  <= st_nxt;
        len_r <= len_nxt;
      end
      if (s1_go && step_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data;
    if (s1_go && step_emit) out_data_r <= step_res;
  end

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        snlm_pkg::REG_SEPARATORS: cfg_r.allow_separators    <= pwdata[0];
        snlm_pkg::REG_OCTAL:      cfg_r.allow_octal_prefix  <= pwdata[0];
        snlm_pkg::REG_BINARY:     cfg_r.allow_binary_prefix <= pwdata[0];
        snlm_pkg::REG_BIGINT:     cfg_r.allow_bigint_suffix <= pwdata[0];
        default:                  cfg_r                     <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      snlm_pkg::REG_SEPARATORS: prdata = 32'(cfg_r.allow_separators);
      snlm_pkg::REG_OCTAL:      prdata = 32'(cfg_r.allow_octal_prefix);
      snlm_pkg::REG_BINARY:     prdata = 32'(cfg_r.allow_binary_prefix);
      snlm_pkg::REG_BIGINT:     prdata = 32'(cfg_r.allow_bigint_suffix);
      default:                  prdata = '0;
    endcase
  end

  `SNLM_ASSERT_IMPLY(a_fail_zero_len, out_valid_r && !out_data_r.matched, out_data_r.match_length == 8'd0, "failed result carries a length")
  `SNLM_ASSERT_NEXT(a_emit_decides, s1_go && step_emit, st_r.decided, "scan not closed after result")
  `SNLM_ASSERT_IMPLY(a_len_limit, 1'b1, len_r <= LEN_W'(MAX_LEN), "literal length past limit")
  `SNLM_ASSERT_IMPLY(a_decided_quiet, s1_go && st_r.decided && !in_data_r.first_char, !step_emit, "result without a pending scan")
  `SNLM_ASSERT_IMPLY(a_stall_cause, !in_ready, in_valid_r && out_valid_r && !out_ready, "input stalled with room downstream")

endmodule

`default_nettype wire
